// ===== design/two_key_priority_queue_unit_assert.svh =====
// Assertion macros for the two-key priority queue unit.
// In synthesis builds the macros expand to nothing.
`ifndef TWO_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TWO_KEY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every edge, masked while reset is high.
`define TPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define TPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define TPQ_ASSERT(lbl, prop, msg)
`define TPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/tpq_pkg.sv =====
package tpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int OccW        = 5;

   localparam logic ModeEnqueue = 1'b0;
   localparam logic ModeDequeue = 1'b1;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusEmpty = 2'd1;
   localparam logic [1:0] StatusFull  = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [15:0]        item_tag;
      logic signed [15:0] primary_key;
      logic signed [15:0] secondary_key;
   } tpq_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        out_tag;
      logic signed [15:0] out_primary;
      logic signed [15:0] out_secondary;
      logic [OccW-1:0]    occupancy;
   } tpq_rsp_type;

   // One held entry.
   typedef struct packed {
      logic [15:0]        tag;
      logic signed [15:0] primary;
      logic signed [15:0] secondary;
   } tpq_entry_type;

   // Chain-wide move for this cycle.
   typedef struct packed {
      logic shift_in;    // enqueue: cells at and behind the slot move back
      logic shift_out;   // dequeue: every cell takes its right neighbour
   } tpq_ctl_type;

endpackage

// ===== design/two_key_priority_queue_unit.sv =====
// Channel   Direction  Payload               Handshake
// req_      in         tpq_pkg::tpq_req_type req_valid / req_stall
// rsp_      out        tpq_pkg::tpq_rsp_type rsp_valid / rsp_stall
//
// One request per cycle; its response appears in the output register on the
// next cycle. The rate is set by the cell chain: every slot compares its key
// pair with the new request in parallel and moves in the same edge.
// Synchronous active-high reset empties the queue and clears rsp_valid.
// A held response stalls the request side (req_stall follows rsp_stall).
`include "two_key_priority_queue_unit_assert.svh"

module two_key_priority_queue_unit #(
   parameter int Depth = tpq_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tpq_pkg::tpq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tpq_pkg::tpq_rsp_type rsp_data
);

   localparam int CountW = $clog2(Depth + 1);
   localparam int OccW   = tpq_pkg::OccW;

   // Handshake and output register
   logic                 req_accept;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   tpq_pkg::tpq_rsp_type rsp_ff;
   tpq_pkg::tpq_rsp_type rsp_in;

   // Queue state
   logic [CountW-1:0]    count_ff;
   logic [CountW-1:0]    count_in;
   logic                 is_full;
   logic                 is_empty;
   logic                 do_enqueue;
   logic                 do_dequeue;
   logic                 empty_deq;
   logic                 head_order_ok;

   tpq_pkg::tpq_ctl_type   ctl;
   tpq_pkg::tpq_entry_type new_entry;
   tpq_pkg::tpq_entry_type cell_entry [Depth];
   logic                   cell_ahead [Depth];
   logic                   cell_occ   [Depth];

   // Stall only while a response is held by the far side.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign is_full  = (count_ff == CountW'(Depth));
   assign is_empty = (count_ff == '0);

   assign do_enqueue = req_accept && (req_data.mode == tpq_pkg::ModeEnqueue) && !is_full;
   assign do_dequeue = req_accept && (req_data.mode == tpq_pkg::ModeDequeue) && !is_empty;
   assign empty_deq  = req_accept && (req_data.mode == tpq_pkg::ModeDequeue) && is_empty;

   assign ctl.shift_in  = do_enqueue;
   assign ctl.shift_out = do_dequeue;

   assign new_entry.tag       = req_data.item_tag;
   assign new_entry.primary   = req_data.primary_key;
   assign new_entry.secondary = req_data.secondary_key;

   // Cell chain: slot 0 is the front. Equal keys never set ahead, so a new
   // entry lands behind older entries with the same key pair.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      assign cell_occ[i] = (CountW'(i) < count_ff);

      if (i == 0) begin : g_head
         if (Depth > 1) begin : g_more
            tpq_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .occupied   (cell_occ[i]),
               .left_ahead (1'b0),
               .new_entry  (new_entry),
               .left_entry (new_entry),
               .right_entry(cell_entry[i+1]),
               .entry      (cell_entry[i]),
               .ahead      (cell_ahead[i])
            );
         end else begin : g_one
            tpq_cell u_cell (
               .clock      (clock),
               .ctl        (ctl),
               .occupied   (cell_occ[i]),
               .left_ahead (1'b0),
               .new_entry  (new_entry),
               .left_entry (new_entry),
               .right_entry(cell_entry[i]),
               .entry      (cell_entry[i]),
               .ahead      (cell_ahead[i])
            );
         end
      end else if (i == Depth - 1) begin : g_tail
         // Tail content after a dequeue is beyond the count; keep it.
         tpq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (cell_occ[i]),
            .left_ahead (cell_ahead[i-1]),
            .new_entry  (new_entry),
            .left_entry (cell_entry[i-1]),
            .right_entry(cell_entry[i]),
            .entry      (cell_entry[i]),
            .ahead      (cell_ahead[i])
         );
      end else begin : g_mid
         tpq_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .occupied   (cell_occ[i]),
            .left_ahead (cell_ahead[i-1]),
            .new_entry  (new_entry),
            .left_entry (cell_entry[i-1]),
            .right_entry(cell_entry[i+1]),
            .entry      (cell_entry[i]),
            .ahead      (cell_ahead[i])
         );
      end
   end

   // Occupancy count
   always_comb begin
      count_in = count_ff;
      if (do_enqueue) begin
         count_in = count_ff + CountW'(1);
      end else if (do_dequeue) begin
         count_in = count_ff - CountW'(1);
      end
   end

   // Response build: out_ fields are zero unless a dequeue succeeds.
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = tpq_pkg::StatusOk;
         rsp_in.out_tag       = '0;
         rsp_in.out_primary   = '0;
         rsp_in.out_secondary = '0;
         rsp_in.occupancy     = OccW'(count_in);
         case (req_data.mode)
            tpq_pkg::ModeEnqueue: begin
               if (is_full) begin
                  rsp_in.status = tpq_pkg::StatusFull;
               end
            end
            tpq_pkg::ModeDequeue: begin
               if (is_empty) begin
                  rsp_in.status = tpq_pkg::StatusEmpty;
               end else begin
                  rsp_in.out_tag       = cell_entry[0].tag;
                  rsp_in.out_primary   = cell_entry[0].primary;
                  rsp_in.out_secondary = cell_entry[0].secondary;
               end
            end
            default: begin
               rsp_in.status = tpq_pkg::StatusOk;
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Front two slots must be in service order when both are held.
   if (Depth > 1) begin : g_order
      assign head_order_ok = ($signed(cell_entry[0].primary) < $signed(cell_entry[1].primary))
         || (($signed(cell_entry[0].primary) == $signed(cell_entry[1].primary))
             && ($signed(cell_entry[0].secondary) <= $signed(cell_entry[1].secondary)));
   end else begin : g_no_order
      assign head_order_ok = 1'b1;
   end

   `TPQ_ASSERT_ALWAYS(a_count_bound, reset || (count_ff <= CountW'(Depth)), "count above depth")
   `TPQ_ASSERT(a_enq_grows, do_enqueue |=> count_ff == $past(count_ff) + CountW'(1), "enqueue lost")
   `TPQ_ASSERT(a_empty, empty_deq |=> rsp_ff.status == tpq_pkg::StatusEmpty, "empty missed")
   `TPQ_ASSERT(a_head_order, (count_ff > CountW'(1)) |-> head_order_ok, "front slots out of order")

endmodule

// ===== design/tpq_cell.sv =====
// One slot of the sorted chain.
module tpq_cell (
   input  logic                  clock,
   input  tpq_pkg::tpq_ctl_type  ctl,
   input  logic                  occupied,
   input  logic                  left_ahead,
   input  tpq_pkg::tpq_entry_type new_entry,
   input  tpq_pkg::tpq_entry_type left_entry,
   input  tpq_pkg::tpq_entry_type right_entry,
   output tpq_pkg::tpq_entry_type entry,
   output logic                  ahead
);

   tpq_pkg::tpq_entry_type entry_ff;
   tpq_pkg::tpq_entry_type entry_in;

   // New entry is served ahead of this slot (an empty slot always loses).
   always_comb begin
      ahead = !occupied
            || ($signed(new_entry.primary) < $signed(entry_ff.primary))
            || (($signed(new_entry.primary) == $signed(entry_ff.primary))
                && ($signed(new_entry.secondary) < $signed(entry_ff.secondary)));
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_out) begin
         entry_in = right_entry;
      end else if (ctl.shift_in) begin
         if (left_ahead) begin
            entry_in = left_entry;
         end else if (ahead) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
